>>> design/bclru_pkg.sv
package bclru_pkg;

  // fixed field widths
  localparam int unsigned TAG_W = 36;
  localparam int unsigned FS_W  = 48;
  localparam int unsigned LEN_W = 16;

  // parameter defaults
  localparam int unsigned NUM_SLOTS_DEF   = 64;
  localparam int unsigned BLOCK_BYTES_DEF = 4096;

  // request kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    ST_ACCESS = 2'd0,
    ST_RANGE  = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FLUSH  = 2'd3
  } status_t;

  typedef struct packed {
    logic             kind;
    logic [FS_W-1:0]  offset;
    logic [LEN_W-1:0] length;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [TAG_W-1:0] block_number;
    logic             hit;
    logic             evicted;
    logic [TAG_W-1:0] evicted_block;
    logic             last;
  } rsp_t;

  // directory operations issued by the sequencer
  typedef enum logic [1:0] {
    DOP_IDLE,
    DOP_LOOKUP,
    DOP_UPDATE,
    DOP_FLUSH
  } dir_op_t;

  typedef struct packed {
    dir_op_t          op;
    logic [TAG_W-1:0] key;
  } dir_ctrl_t;

  typedef struct packed {
    logic             hit;
    logic             full;
    logic [TAG_W-1:0] lru_tag;
  } dir_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DISPATCH,
    S_LOOKUP,
    S_UPDATE
  } fsm_state_t;

endpackage

>>> design/bclru_cell.sv
module bclru_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  bclru_pkg::dir_ctrl_t      ctrl,
  input  logic                      occupied,
  input  logic                      load,
  input  logic [bclru_pkg::TAG_W-1:0] tag_in,
  input  logic                      shift_in,
  output logic                      shift_out,
  output logic [bclru_pkg::TAG_W-1:0] tag,
  output logic                      match
);

  logic match_q;

  // shift once any older cell (or this one) matched, or on a full-miss eviction
  assign shift_out = shift_in | match_q;
  assign match     = match_q;

  // capture tag compare during lookup
  always_ff @(posedge clk) begin
    if (rst) begin
      match_q <= 1'b0;
    end else if (ctrl.op == bclru_pkg::DOP_LOOKUP) begin
      match_q <= occupied && (tag == ctrl.key);
    end else if (ctrl.op == bclru_pkg::DOP_UPDATE || ctrl.op == bclru_pkg::DOP_FLUSH) begin
      match_q <= 1'b0;
    end
  end

  // load the new block as most recent, or take the neighbor's tag
  always_ff @(posedge clk) begin
    if (ctrl.op == bclru_pkg::DOP_UPDATE) begin
      if (load) begin
        tag <= ctrl.key;
      end else if (shift_out) begin
        tag <= tag_in;
      end
    end
  end

endmodule

>>> design/bclru_chain.sv
module bclru_chain #(
  parameter int unsigned NUM_SLOTS = bclru_pkg::NUM_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bclru_pkg::dir_ctrl_t ctrl,
  output bclru_pkg::dir_stat_t stat
);

  localparam int unsigned CNT_W = $clog2(NUM_SLOTS + 1);

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          dest;
  logic                      hit;
  logic                      full;
  logic [NUM_SLOTS-1:0]      match;
  logic [NUM_SLOTS:0]        shift;
  logic [bclru_pkg::TAG_W-1:0] tags [NUM_SLOTS];

  assign hit  = |match;
  assign full = (count == CNT_W'(NUM_SLOTS));
  // hit or full miss writes the top occupied slot, otherwise the first free one
  assign dest = (hit || full) ? (count - CNT_W'(1)) : count;
  assign shift[0] = !hit && full;

  assign stat.hit     = hit;
  assign stat.full    = full;
  assign stat.lru_tag = tags[0];

  // row of slot cells, slot 0 least recent
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    logic [bclru_pkg::TAG_W-1:0] nbr_tag;
    if (i == NUM_SLOTS - 1) begin : g_top
      assign nbr_tag = ctrl.key;
    end else begin : g_mid
      assign nbr_tag = tags[i+1];
    end
    bclru_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .occupied  (CNT_W'(i) < count),
      .load      (CNT_W'(i) == dest),
      .tag_in    (nbr_tag),
      .shift_in  (shift[i]),
      .shift_out (shift[i+1]),
      .tag       (tags[i]),
      .match     (match[i])
    );
  end

  // track number of occupied slots
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.op == bclru_pkg::DOP_FLUSH) begin
      count <= '0;
    end else if (ctrl.op == bclru_pkg::DOP_UPDATE && !hit && !full) begin
      count <= count + CNT_W'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(NUM_SLOTS))
    else $error("slot count beyond capacity");

  a_unique_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("block cached in more than one slot");

  a_hit_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == bclru_pkg::DOP_UPDATE && (hit || full)) |=> count == $past(count))
    else $error("count changed on hit or full eviction");

endmodule

>>> design/block_cache_lru_directory.sv
// Tag and LRU replacement directory of a fully associative block cache.
//
// Channels: req (valid/stall) carries one word per read or flush request;
// rsp (valid/stall) returns one word per touched block, or one single word
// for a flush, an out-of-range read or an empty read; last marks the final
// word of a request. cfg (valid/ready, always ready) writes the file length.
//
// Sequence: a request is accepted only while the sequencer is idle. A check
// state for range check and clipping and a dispatch state follow, then each
// touched block passes a lookup state, which compares the key in every slot
// cell, and an update state, which updates the recency row and registers
// the result word. A single-word result is registered from the dispatch
// state, the first access word from the first update state. The separate
// lookup state comes from the registered compare in the slot cells ahead
// of the shift of the recency row.
//
// A stalled rsp holds its word; the sequencer waits with the next update
// until the output register is free. Reset empties the directory and sets
// the file length to zero; no clearing pass is needed.
module block_cache_lru_directory #(
  parameter int unsigned NUM_SLOTS   = bclru_pkg::NUM_SLOTS_DEF,
  parameter int unsigned BLOCK_BYTES = bclru_pkg::BLOCK_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  bclru_pkg::req_t            req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output bclru_pkg::rsp_t            rsp,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bclru_pkg::FS_W-1:0] cfg_data
);

  localparam int unsigned BB_LOG = $clog2(BLOCK_BYTES);
  localparam int unsigned FS_W   = bclru_pkg::FS_W;
  localparam int unsigned TAG_W  = bclru_pkg::TAG_W;

  bclru_pkg::fsm_state_t state, state_next;
  bclru_pkg::req_t       req_q;
  bclru_pkg::dir_ctrl_t  dir_ctrl;
  bclru_pkg::dir_stat_t  dir_stat;
  bclru_pkg::rsp_t       rsp_next;

  logic [FS_W-1:0] file_len;
  logic            oor;
  logic [FS_W:0]   end_excl;
  logic [FS_W:0]   sum;
  logic [FS_W:0]   end_m1;
  logic [FS_W-1:0] cur_blk;
  logic [FS_W-1:0] last_blk;
  logic            out_free;
  logic            single;
  logic            emit;
  logic            is_last;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != bclru_pkg::S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign single    = (req_q.kind == bclru_pkg::KIND_FLUSH) || oor ||
                     (req_q.length == '0);
  assign is_last   = (cur_blk == last_blk);
  assign sum       = {1'b0, req_q.offset} + (FS_W+1)'(req_q.length);
  assign end_m1    = end_excl - (FS_W+1)'(1);

  // hold the file length register
  always_ff @(posedge clk) begin
    if (rst) begin
      file_len <= '0;
    end else if (cfg_valid && cfg_ready) begin
      file_len <= cfg_data;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bclru_pkg::S_IDLE:     if (req_valid) state_next = bclru_pkg::S_CHECK;
      bclru_pkg::S_CHECK:    state_next = bclru_pkg::S_DISPATCH;
      bclru_pkg::S_DISPATCH: begin
        if (!single) state_next = bclru_pkg::S_LOOKUP;
        else if (out_free) state_next = bclru_pkg::S_IDLE;
      end
      bclru_pkg::S_LOOKUP:   state_next = bclru_pkg::S_UPDATE;
      bclru_pkg::S_UPDATE: begin
        if (out_free) state_next = is_last ? bclru_pkg::S_IDLE : bclru_pkg::S_LOOKUP;
      end
      default:               state_next = bclru_pkg::S_IDLE;
    endcase
  end

  // outputs: directory commands and the result word
  always_comb begin
    dir_ctrl.op  = bclru_pkg::DOP_IDLE;
    dir_ctrl.key = cur_blk[TAG_W-1:0];
    emit         = 1'b0;
    rsp_next     = '0;
    rsp_next.last = 1'b1;
    unique case (state)
      bclru_pkg::S_DISPATCH: begin
        if (single && out_free) begin
          emit = 1'b1;
          priority if (req_q.kind == bclru_pkg::KIND_FLUSH) begin
            rsp_next.status = bclru_pkg::ST_FLUSH;
            dir_ctrl.op     = bclru_pkg::DOP_FLUSH;
          end else if (oor) begin
            rsp_next.status = bclru_pkg::ST_RANGE;
          end else begin
            rsp_next.status = bclru_pkg::ST_EMPTY;
          end
        end
      end
      bclru_pkg::S_LOOKUP: begin
        dir_ctrl.op = bclru_pkg::DOP_LOOKUP;
      end
      bclru_pkg::S_UPDATE: begin
        if (out_free) begin
          emit                   = 1'b1;
          dir_ctrl.op            = bclru_pkg::DOP_UPDATE;
          rsp_next.status        = bclru_pkg::ST_ACCESS;
          rsp_next.block_number  = cur_blk[TAG_W-1:0];
          rsp_next.hit           = dir_stat.hit;
          rsp_next.evicted       = !dir_stat.hit && dir_stat.full;
          rsp_next.evicted_block = (!dir_stat.hit && dir_stat.full) ? dir_stat.lru_tag : '0;
          rsp_next.last          = is_last;
        end
      end
      default: ;
    endcase
  end

  // advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bclru_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the request, clip it and step through its blocks
  always_ff @(posedge clk) begin
    if (state == bclru_pkg::S_IDLE && req_valid) begin
      req_q <= req;
    end
    if (state == bclru_pkg::S_CHECK) begin
      oor      <= (req_q.offset >= file_len);
      end_excl <= (sum > {1'b0, file_len}) ? {1'b0, file_len} : sum;
    end
    if (state == bclru_pkg::S_DISPATCH) begin
      cur_blk  <= FS_W'(req_q.offset >> BB_LOG);
      last_blk <= FS_W'(end_m1 >> BB_LOG);
    end else if (state == bclru_pkg::S_UPDATE && out_free) begin
      cur_blk  <= cur_blk + FS_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp <= rsp_next;
    end
  end

  bclru_chain #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_chain (
    .clk  (clk),
    .rst  (rst),
    .ctrl (dir_ctrl),
    .stat (dir_stat)
  );

  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != bclru_pkg::ST_ACCESS) |-> rsp.last)
    else $error("single result word without last");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.evicted) |-> !rsp.hit)
    else $error("eviction reported on a hit");

  a_update_emits: assert property (@(posedge clk) disable iff (rst)
    (dir_ctrl.op == bclru_pkg::DOP_UPDATE) |=>
      (rsp_valid && rsp.status == bclru_pkg::ST_ACCESS))
    else $error("directory update without access word");

endmodule

>>> dv/testbench.sv
module testbench;

  localparam int unsigned SLOTS       = bclru_pkg::NUM_SLOTS_DEF;
  localparam int unsigned BLK_BYTES   = bclru_pkg::BLOCK_BYTES_DEF;
  localparam int unsigned FS_W        = bclru_pkg::FS_W;
  localparam int unsigned TAG_W       = bclru_pkg::TAG_W;
  localparam int unsigned LEN_W       = bclru_pkg::LEN_W;
  localparam logic [63:0] OFFSET_MAX  = 64'hFFFF_FFFF_FFFF;
  localparam int unsigned SETTLE      = 12;
  localparam int unsigned QUIET_LIMIT = 1000;

  logic            clk;
  logic            rst;
  logic            req_valid;
  logic            req_stall;
  bclru_pkg::req_t req;
  logic            rsp_valid;
  logic            rsp_stall;
  bclru_pkg::rsp_t rsp;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [FS_W-1:0] cfg_data;

  // Mirror of the directory: index 0 is the least recently used block
  logic [63:0]      cur_file_len;
  logic [TAG_W-1:0] lru_order[$];
  bclru_pkg::rsp_t  pending_words[$];
  int unsigned      fail_count = 0;
  bit               idle_on    = 1'b1;

  block_cache_lru_directory #(
    .NUM_SLOTS  (SLOTS),
    .BLOCK_BYTES(BLK_BYTES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bclru_pkg::req_t req_word(logic kind, logic [63:0] off,
                                               logic [63:0] len);
    bclru_pkg::req_t w;
    w.kind   = kind;
    w.offset = off[FS_W-1:0];
    w.length = len[LEN_W-1:0];
    return w;
  endfunction

  function automatic bclru_pkg::rsp_t single_word(bclru_pkg::status_t st);
    bclru_pkg::rsp_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  // Work out the words one request produces and update the mirrored directory
  task automatic predict_access(input bclru_pkg::req_t w);
    logic [63:0]      off;
    logic [63:0]      len;
    logic [63:0]      first_blk;
    logic [63:0]      final_blk;
    logic [63:0]      b;
    logic [TAG_W-1:0] tag;
    logic [TAG_W-1:0] victim;
    bit               found;
    bit               evict;
    bclru_pkg::rsp_t  r;
    off = 64'(w.offset);
    len = 64'(w.length);
    if (w.kind == bclru_pkg::KIND_FLUSH) begin
      lru_order.delete();
      pending_words.push_back(single_word(bclru_pkg::ST_FLUSH));
    end else if (off >= cur_file_len) begin
      pending_words.push_back(single_word(bclru_pkg::ST_RANGE));
    end else begin
      // clip at end of file
      if (off + len > cur_file_len) len = cur_file_len - off;
      if (len == 64'd0) begin
        pending_words.push_back(single_word(bclru_pkg::ST_EMPTY));
      end else begin
        first_blk = off / 64'(BLK_BYTES);
        final_blk = (off + len - 64'd1) / 64'(BLK_BYTES);
        for (b = first_blk; b <= final_blk; b++) begin
          tag    = b[TAG_W-1:0];
          found  = 1'b0;
          evict  = 1'b0;
          victim = '0;
          for (int i = 0; i < lru_order.size(); i++) begin
            if (lru_order[i] == tag) begin
              lru_order.delete(i);
              found = 1'b1;
              break;
            end
          end
          // on a miss with every slot taken, drop the oldest block
          if (!found && lru_order.size() >= SLOTS) begin
            victim = lru_order.pop_front();
            evict  = 1'b1;
          end
          lru_order.push_back(tag);
          r.status        = bclru_pkg::ST_ACCESS;
          r.block_number  = tag;
          r.hit           = found;
          r.evicted       = evict;
          r.evicted_block = victim;
          r.last          = (b == final_blk);
          pending_words.push_back(r);
        end
      end
    end
  endtask

  // Offer one request word, at times with a random gap ahead of it
  task automatic send_word(input bclru_pkg::req_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (req_stall);
    predict_access(w);
  endtask

  // Hold off until every expected word is back and the sequencer has settled
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_file_len(input logic [63:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value[FS_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    cur_file_len  = value & OFFSET_MAX;
  endtask

  function automatic logic [TAG_W-1:0] random_base();
    logic [63:0]      raw;
    logic [TAG_W-1:0] tag;
    raw = {$urandom(), $urandom()};
    tag = raw[TAG_W-1:0];
    if (tag > 36'hF_FFFF_FF00) tag = tag - TAG_W'(256);
    return tag;
  endfunction

  // Mostly reads inside a window of blocks, plus flushes, rejects and noise
  function automatic bclru_pkg::req_t random_item(logic [TAG_W-1:0] base,
                                                  int unsigned span);
    logic [63:0] raw;
    logic [63:0] off;
    logic [63:0] len;
    int unsigned pick;
    int unsigned lsel;
    raw  = {$urandom(), $urandom()};
    pick = $urandom_range(0, 99);
    lsel = $urandom_range(0, 9);
    if (lsel == 0) len = 64'd0;
    else if (lsel < 5) len = 64'($urandom_range(1, BLK_BYTES));
    else if (lsel < 9) len = 64'($urandom_range(1, 65535));
    else len = 64'd65535;
    if (pick < 4) return req_word(bclru_pkg::KIND_FLUSH, raw, 64'(raw[63:48]));
    if (pick < 14) begin
      off = cur_file_len + 64'($urandom_range(0, 5000));
      if (off > OFFSET_MAX) off = OFFSET_MAX;
      return req_word(bclru_pkg::KIND_READ, off, len);
    end
    if (pick < 22) return req_word(bclru_pkg::KIND_READ, raw, 64'(raw[63:48]));
    off = 64'(base) * 64'(BLK_BYTES) + 64'($urandom_range(0, span * BLK_BYTES - 1));
    return req_word(bclru_pkg::KIND_READ, off, len);
  endfunction

  // One setting of the file length, with a full drain halfway through
  task automatic run_traffic(input logic [63:0] fsize, input logic [TAG_W-1:0] base,
                             input int unsigned span, input int unsigned count);
    write_file_len(fsize);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_drained();
      send_word(random_item(base, span));
    end
  endtask

  // file length is zero out of reset: every read is out of range
  task automatic test_unconfigured();
    send_word(req_word(bclru_pkg::KIND_READ, 0, 1));
    send_word(req_word(bclru_pkg::KIND_READ, 0, 0));
    send_word(req_word(bclru_pkg::KIND_FLUSH, 0, 0));
  endtask

  task automatic test_field_limits();
    write_file_len(OFFSET_MAX);
    send_word(req_word(bclru_pkg::KIND_READ, 0, 0));
    send_word(req_word(bclru_pkg::KIND_READ, OFFSET_MAX, 1));
    send_word(req_word(bclru_pkg::KIND_READ, OFFSET_MAX - 64'd1, 16'hFFFF));
    send_word(req_word(bclru_pkg::KIND_READ, BLK_BYTES - 1, 16'hFFFF));
    send_word(req_word(bclru_pkg::KIND_READ, 0, 16'hFFFF));
    send_word(req_word(bclru_pkg::KIND_FLUSH, OFFSET_MAX, 16'hFFFF));
    write_file_len(1);
    send_word(req_word(bclru_pkg::KIND_READ, 0, 16'hFFFF));
    send_word(req_word(bclru_pkg::KIND_READ, 1, 0));
    write_file_len(0);
    send_word(req_word(bclru_pkg::KIND_READ, 0, 0));
  endtask

  // Fill past capacity, then check that a hit protects the oldest block
  task automatic test_lru_eviction();
    write_file_len(OFFSET_MAX);
    send_word(req_word(bclru_pkg::KIND_FLUSH, 0, 0));
    for (int k = 0; k < 5; k++)
      send_word(req_word(bclru_pkg::KIND_READ, k * 16 * BLK_BYTES, 16'hFFFF));
    send_word(req_word(bclru_pkg::KIND_READ, 16 * BLK_BYTES, 1));
    send_word(req_word(bclru_pkg::KIND_READ, 0, 1));
    send_word(req_word(bclru_pkg::KIND_READ, 16 * BLK_BYTES + 5, 100));
  endtask

  task automatic test_wide_window();
    run_traffic(OFFSET_MAX, random_base(), 96, 25);
  endtask

  // End of file falls inside the window, so many reads get clipped
  task automatic test_clipped_tail();
    logic [TAG_W-1:0] base;
    logic [63:0]      fs;
    base = random_base();
    fs   = 64'(base) * 64'(BLK_BYTES) + 64'(40 * BLK_BYTES) +
           64'($urandom_range(0, BLK_BYTES - 1));
    run_traffic(fs, base, 48, 20);
  endtask

  task automatic test_small_file();
    run_traffic(3 * BLK_BYTES + 7, '0, 4, 15);
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    run_traffic(OFFSET_MAX, random_base(), 80, 30);
  endtask

  // Stall the response side in random bursts while idle gaps are on
  initial begin
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, logic [TAG_W-1:0] exp_v,
                                      logic [TAG_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Compare each accepted response word with the oldest expectation
  always @(posedge clk) begin : check_rsp
    bclru_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_words.size() == 0) begin
        $error("unexpected rsp word: status %0d block %0h", rsp.status, rsp.block_number);
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        check_field("status", TAG_W'(want.status), TAG_W'(rsp.status));
        check_field("block_number", want.block_number, rsp.block_number);
        check_field("hit", TAG_W'(want.hit), TAG_W'(rsp.hit));
        check_field("evicted", TAG_W'(want.evicted), TAG_W'(rsp.evicted));
        check_field("evicted_block", want.evicted_block, rsp.evicted_block);
        check_field("last", TAG_W'(want.last), TAG_W'(rsp.last));
      end
    end
  end

  // End the run if no word moves on any channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("block_cache_lru_directory test failed");
    $finish;
  end

  initial begin
    rst          <= 1'b1;
    req_valid    <= 1'b0;
    req          <= '0;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    cur_file_len  = 64'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_unconfigured();
    test_field_limits();
    test_lru_eviction();
    test_wide_window();
    test_clipped_tail();
    test_small_file();
    test_back_to_back();

    wait_drained();
    if (fail_count == 0)
      $display("block_cache_lru_directory test passed");
    else
      $display("block_cache_lru_directory test failed");
    $finish;
  end

endmodule

>>> filelist.f
design/bclru_pkg.sv
design/bclru_cell.sv
design/bclru_chain.sv
design/block_cache_lru_directory.sv
dv/testbench.sv
